>>> rtl/assert_macros.svh
// Concurrent check helpers clocked on clk_i and held off during rst_ni low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define BPMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define BPMC_NEVER(lbl, cond, msg) \
  `BPMC_ASSERT(lbl, !(cond), msg)

`endif

>>> rtl/bpmc_pkg.sv
`timescale 1ns / 1ps

package bpmc_pkg;

  localparam int HistoryDefault = 2;

  localparam int TempW = 12;
  localparam int AgeW = 20;
  localparam int SinceW = 10;
  localparam int RunW = 4;
  localparam int PhaseW = 8;

  localparam logic [AgeW-1:0] AgeMax = '1;
  localparam logic [SinceW-1:0] SinceMax = '1;
  localparam logic [RunW-1:0] RunMax = '1;

  localparam int AddrW = 5;
  localparam int DataW = 32;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_READY = 2'd1,
    MODE_PUMP  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_OFF  = 2'd1,
    CMD_ON   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    REG_SETPOINT  = 3'd0,
    REG_DEBOUNCE  = 3'd1,
    REG_PERIOD    = 3'd2,
    REG_AUTO_OFF  = 3'd3,
    REG_HEAT_DEAD = 3'd4,
    REG_PUMP_DEAD = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [TempW-1:0]  setpoint;
    logic [RunW-1:0]   debounce;
    logic [PhaseW-1:0] period;
    logic [AgeW-1:0]   auto_off;
    logic [SinceW-1:0] heat_dead;
    logic [SinceW-1:0] pump_dead;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic             open;
    logic [TempW-1:0] sample;
    logic             button;
  } tick_t;

  typedef struct packed {
    logic             over;
    logic             fault;
    logic [TempW-1:0] average;
  } samp_res_t;

  typedef struct packed {
    logic             measured;
    logic             fault;
    logic [TempW-1:0] average;
    logic [1:0]       mode;
    logic             pump;
    logic             heat;
  } result_t;

endpackage

>>> rtl/bpmc_cfg_regs.sv
`timescale 1ns / 1ps

module bpmc_cfg_regs import bpmc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;
  logic wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint  <= TempW'(364);
      cfg_q.debounce  <= RunW'(5);
      cfg_q.period    <= PhaseW'(25);
      cfg_q.auto_off  <= AgeW'(360000);
      cfg_q.heat_dead <= SinceW'(100);
      cfg_q.pump_dead <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_SETPOINT:  cfg_q.setpoint  <= pwdata[TempW-1:0];
        REG_DEBOUNCE:  cfg_q.debounce  <= pwdata[RunW-1:0];
        REG_PERIOD:    cfg_q.period    <= pwdata[PhaseW-1:0];
        REG_AUTO_OFF:  cfg_q.auto_off  <= pwdata[AgeW-1:0];
        REG_HEAT_DEAD: cfg_q.heat_dead <= pwdata[SinceW-1:0];
        REG_PUMP_DEAD: cfg_q.pump_dead <= pwdata[SinceW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SETPOINT:  prdata = DataW'(cfg_q.setpoint);
      REG_DEBOUNCE:  prdata = DataW'(cfg_q.debounce);
      REG_PERIOD:    prdata = DataW'(cfg_q.period);
      REG_AUTO_OFF:  prdata = DataW'(cfg_q.auto_off);
      REG_HEAT_DEAD: prdata = DataW'(cfg_q.heat_dead);
      REG_PUMP_DEAD: prdata = DataW'(cfg_q.pump_dead);
      default:       prdata = '0;
    endcase
  end

endmodule

>>> rtl/bpmc_samples.sv
`timescale 1ns / 1ps

module bpmc_samples import bpmc_pkg::*; #(
  parameter int HISTORY = HistoryDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             measure_i,
  input  logic [TempW-1:0] sample_i,
  input  logic             open_i,
  input  logic [TempW-1:0] setpoint_i,
  output samp_res_t        res_o
);

  localparam int LogH   = $clog2(HISTORY);
  localparam int PtrW   = (HISTORY > 1) ? LogH : 1;
  localparam int SumW   = TempW + LogH;
  localparam int Shift  = SumW + LogH;
  localparam int Recip  = ((1 << Shift) + HISTORY - 1) / HISTORY;
  localparam int ProdW  = 2 * SumW + 1;

  logic [TempW-1:0]   store_q [HISTORY];
  logic [HISTORY-1:0] open_q, open_d;
  logic [PtrW-1:0]    ptr_q, ptr_d;
  logic [SumW-1:0]    sum_q, sum_d, limit;
  logic [ProdW-1:0]   prod;

  always_comb begin
    open_d = open_q;
    sum_d  = sum_q;
    ptr_d  = ptr_q;
    if (measure_i) begin
      open_d[ptr_q] = open_i;
      sum_d = sum_q - SumW'(store_q[ptr_q]) + SumW'(sample_i);
      ptr_d = (ptr_q == PtrW'(HISTORY - 1)) ? '0 : ptr_q + PtrW'(1);
    end
    limit = SumW'(setpoint_i) * SumW'(HISTORY);
    prod  = ProdW'(sum_d) * ProdW'(Recip);
  end

  assign res_o.over    = sum_d > limit;
  assign res_o.fault   = |open_d;
  assign res_o.average = prod[Shift +: TempW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HISTORY; i++) begin
        store_q[i] <= '0;
      end
      open_q <= '0;
      ptr_q  <= '0;
      sum_q  <= '0;
    end else if (step_i && measure_i) begin
      store_q[ptr_q] <= sample_i;
      open_q         <= open_d;
      ptr_q          <= ptr_d;
      sum_q          <= sum_d;
    end
  end

endmodule

>>> rtl/bpmc_tick_core.sv
`timescale 1ns / 1ps

module bpmc_tick_core import bpmc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  tick_t     tick_i,
  input  cfg_t      cfg_i,
  input  samp_res_t samp_i,
  output logic      measure_o,
  output result_t   result_o
);

  mode_e             mode_q, mode_a, mode_b, mode_d;
  logic              level_q, level_d;
  logic [RunW-1:0]   run_q, run_d;
  logic [PhaseW-1:0] phase_q, phase_d, phase_inc;
  logic [AgeW-1:0]   age_q, age_d, age_inc, age_b;
  logic              heat_q, heat_d, pump_q, pump_d;
  logic [SinceW-1:0] hsince_q, hsince_d, hsince_inc;
  logic [SinceW-1:0] psince_q, psince_d, psince_inc;
  logic              heat_want, pump_want, heat_sw, pump_sw, clr, measure;

  assign phase_inc = phase_q + PhaseW'(1);
  assign measure   = phase_inc >= cfg_i.period;
  assign phase_d   = measure ? '0 : phase_inc;

  always_comb begin
    age_inc    = (age_q == AgeMax) ? age_q : age_q + AgeW'(1);
    hsince_inc = (hsince_q == SinceMax) ? hsince_q : hsince_q + SinceW'(1);
    psince_inc = (psince_q == SinceMax) ? psince_q : psince_q + SinceW'(1);

    run_d   = run_q;
    level_d = level_q;
    mode_a  = mode_q;
    if (mode_q != MODE_OFF) begin
      if (tick_i.button != level_q) begin
        run_d = (run_q == RunMax) ? run_q : run_q + RunW'(1);
      end else begin
        run_d = '0;
      end
      if (run_d >= cfg_i.debounce) level_d = tick_i.button;
      mode_a = level_d ? MODE_PUMP : MODE_READY;
    end

    mode_b = mode_a;
    case (tick_i.cmd)
      CMD_OFF: mode_b = MODE_OFF;
      CMD_ON:  mode_b = MODE_READY;
      default: ;
    endcase

    clr   = (mode_a != mode_q) || (mode_b != mode_a);
    age_b = clr ? '0 : age_inc;

    mode_d    = mode_b;
    age_d     = age_b;
    heat_want = heat_q;
    pump_want = pump_q;
    if (measure) begin
      unique case (mode_b)
        MODE_PUMP: begin
          pump_want = 1'b1;
          heat_want = 1'b1;
        end
        MODE_READY: begin
          pump_want = 1'b0;
          heat_want = !(samp_i.fault || samp_i.over);
          if (age_b > cfg_i.auto_off) begin
            mode_d = MODE_OFF;
            age_d  = '0;
          end
        end
        default: begin
          pump_want = 1'b0;
          heat_want = 1'b0;
        end
      endcase
    end

    heat_sw  = (heat_want != heat_q) && (hsince_inc > cfg_i.heat_dead);
    pump_sw  = (pump_want != pump_q) && (psince_inc > cfg_i.pump_dead);
    heat_d   = heat_sw ? heat_want : heat_q;
    pump_d   = pump_sw ? pump_want : pump_q;
    hsince_d = heat_sw ? '0 : hsince_inc;
    psince_d = pump_sw ? '0 : psince_inc;
  end

  assign measure_o         = measure;
  assign result_o.heat     = heat_d;
  assign result_o.pump     = pump_d;
  assign result_o.mode     = mode_d;
  assign result_o.average  = samp_i.average;
  assign result_o.fault    = samp_i.fault;
  assign result_o.measured = measure;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_READY;
      level_q  <= 1'b0;
      run_q    <= '0;
      phase_q  <= '0;
      age_q    <= '0;
      heat_q   <= 1'b0;
      pump_q   <= 1'b0;
      hsince_q <= SinceMax;
      psince_q <= SinceMax;
    end else if (step_i) begin
      mode_q   <= mode_d;
      level_q  <= level_d;
      run_q    <= run_d;
      phase_q  <= phase_d;
      age_q    <= age_d;
      heat_q   <= heat_d;
      pump_q   <= pump_d;
      hsince_q <= hsince_d;
      psince_q <= psince_d;
    end
  end

endmodule

>>> rtl/boiler_pump_mode_controller_core.sv
`timescale 1ns / 1ps

// Boiler pump mode controller. Each stream beat in is one 10 ms tick; each
// beat out is the relay drive, mode and averaged temperature after that tick.
// A tick is taken into an input register, worked through combinationally and
// written to the result register, so a beat is accepted every cycle and its
// result is presented from the result register; only the output side's tready
// stalls the flow. Sample history resets to zero in flip-flops, so no clearing
// pass runs after reset. The user must write registers on the APB port only
// while no beat is in flight; the block itself does not enforce this.
`include "assert_macros.svh"

module boiler_pump_mode_controller_core import bpmc_pkg::*; #(
  parameter int HISTORY = HistoryDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // [0] button_pressed, [12:1] temp_sample, [13] temp_open, [15:14] remote_cmd
  input  logic [15:0]      s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // [0] heat_on, [1] pump_on, [3:2] mode, [15:4] temp_average,
  // [16] temp_fault, [17] measured, [23:18] zero
  output logic [23:0]      m_axis_tdata,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t      cfg;
  samp_res_t samp;
  result_t   result, res_q;
  tick_t     tick_q;
  logic      in_valid_q, out_valid_q, advance, measure, s_accept;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = 24'(res_q);

  bpmc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bpmc_samples #(.HISTORY(HISTORY)) u_samples (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .measure_i  (measure),
    .sample_i   (tick_q.sample),
    .open_i     (tick_q.open),
    .setpoint_i (cfg.setpoint),
    .res_o      (samp)
  );

  bpmc_tick_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .tick_i    (tick_q),
    .cfg_i     (cfg),
    .samp_i    (samp),
    .measure_o (measure),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= s_accept || (in_valid_q && !advance);
      out_valid_q <= advance || (out_valid_q && !m_axis_tready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      tick_q <= tick_t'(s_axis_tdata);
    end
    if (advance) begin
      res_q <= result;
    end
  end

  `BPMC_ASSERT(a_ready_only_on_stall, !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready, "input stalled without a full pipe")
  `BPMC_ASSERT(a_out_from_advance, $rose(m_axis_tvalid) |-> $past(advance), "result raised without a processed tick")
  `BPMC_NEVER(a_mode_code, m_axis_tvalid && (m_axis_tdata[3:2] == 2'd3), "result carries undefined mode")

endmodule

>>> sim/boiler_pump_mode_controller_core_test.sv
`timescale 1ns / 1ps

module boiler_pump_mode_controller_core_test;
  import bpmc_pkg::*;

  localparam int HIST = HistoryDefault;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [15:0]      s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [23:0]      m_axis_tdata;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  boiler_pump_mode_controller_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cfg_t              cfg;
  mode_e             mode_q;
  logic              btn_level;
  logic [RunW-1:0]   btn_run;
  logic [PhaseW-1:0] phase;
  logic [AgeW-1:0]   mode_age;
  logic [TempW-1:0]  samples [HIST];
  logic              sample_bad [HIST];
  int                wr_ptr;
  logic              heat_lvl;
  logic              pump_lvl;
  logic [SinceW-1:0] heat_since;
  logic [SinceW-1:0] pump_since;

  tick_t   ticks_to_send [$];
  result_t due_results [$];
  int      beats_in = 0;
  int      errors = 0;
  int      hold_left = 0;
  bit      held = 1'b0;
  result_t got;
  result_t want;

  function automatic void reset_model();
    cfg.setpoint = 12'd364;
    cfg.debounce = 4'd5;
    cfg.period = 8'd25;
    cfg.auto_off = 20'd360000;
    cfg.heat_dead = 10'd100;
    cfg.pump_dead = 10'd0;
    mode_q = MODE_READY;
    btn_level = 1'b0;
    btn_run = '0;
    phase = '0;
    mode_age = '0;
    for (int i = 0; i < HIST; i++) begin
      samples[i] = '0;
      sample_bad[i] = 1'b0;
    end
    wr_ptr = 0;
    heat_lvl = 1'b0;
    pump_lvl = 1'b0;
    heat_since = SinceMax;
    pump_since = SinceMax;
  endfunction

  function automatic int stored_sum();
    int s;
    s = 0;
    for (int i = 0; i < HIST; i++) s += int'(samples[i]);
    return s;
  endfunction

  function automatic logic stored_fault();
    logic f;
    f = 1'b0;
    for (int i = 0; i < HIST; i++) f |= sample_bad[i];
    return f;
  endfunction

  function automatic void set_mode(mode_e m);
    if (m != mode_q) begin
      mode_q = m;
      mode_age = '0;
    end
  endfunction

  function automatic void move_relay(inout logic lvl, inout logic [SinceW-1:0] since,
                                     input logic [SinceW-1:0] dead, input logic target);
    if (target != lvl && since > dead) begin
      lvl = target;
      since = '0;
    end
  endfunction

  function automatic result_t step_boiler(tick_t t);
    result_t r;
    logic    took;
    logic    hot;
    took = 1'b0;
    if (mode_age != AgeMax) mode_age++;
    if (heat_since != SinceMax) heat_since++;
    if (pump_since != SinceMax) pump_since++;
    if (mode_q != MODE_OFF) begin
      if (t.button != btn_level) begin
        if (btn_run != RunMax) btn_run++;
      end else begin
        btn_run = '0;
      end
      if (btn_run >= cfg.debounce) btn_level = t.button;
      set_mode(btn_level ? MODE_PUMP : MODE_READY);
    end
    if (t.cmd == CMD_OFF) set_mode(MODE_OFF);
    else if (t.cmd == CMD_ON) set_mode(MODE_READY);
    phase++;
    if (phase >= cfg.period) begin
      phase = '0;
      took = 1'b1;
      if (wr_ptr >= HIST) wr_ptr = 0;
      samples[wr_ptr] = t.sample;
      sample_bad[wr_ptr] = t.open;
      wr_ptr = (wr_ptr + 1 >= HIST) ? 0 : wr_ptr + 1;
      case (mode_q)
        MODE_PUMP: begin
          move_relay(pump_lvl, pump_since, cfg.pump_dead, 1'b1);
          move_relay(heat_lvl, heat_since, cfg.heat_dead, 1'b1);
        end
        MODE_READY: begin
          hot = stored_fault() || (stored_sum() > int'(cfg.setpoint) * HIST);
          move_relay(pump_lvl, pump_since, cfg.pump_dead, 1'b0);
          move_relay(heat_lvl, heat_since, cfg.heat_dead, !hot);
          if (mode_age > cfg.auto_off) set_mode(MODE_OFF);
        end
        default: begin
          move_relay(heat_lvl, heat_since, cfg.heat_dead, 1'b0);
          move_relay(pump_lvl, pump_since, cfg.pump_dead, 1'b0);
        end
      endcase
    end
    r.heat = heat_lvl;
    r.pump = pump_lvl;
    r.mode = mode_q;
    r.average = TempW'(stored_sum() / HIST);
    r.fault = stored_fault();
    r.measured = took;
    return r;
  endfunction

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // Source: accept beats into the model, then offer the next tick.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        due_results.push_back(step_boiler(tick_t'(s_axis_tdata)));
        beats_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (ticks_to_send.size() != 0 &&
            ((beats_in >= 600 && beats_in < 760) || hold_left != 0 ||
             $urandom_range(99) >= 24)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= ticks_to_send.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink: check each beat, stall at random, hold off once for a long stretch.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: beat with nothing expected, actual %h", $time, m_axis_tdata);
        end else begin
          want = due_results.pop_front();
          check_field("heat_on", want.heat, got.heat);
          check_field("pump_on", want.pump, got.pump);
          check_field("mode", want.mode, got.mode);
          check_field("temp_average", want.average, got.average);
          check_field("temp_fault", want.fault, got.fault);
          check_field("measured", want.measured, got.measured);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!held && beats_in >= 300) begin
        held = 1'b1;
        hold_left = 80;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (beats_in >= 600 && beats_in < 760) || $urandom_range(99) >= 24;
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, int val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= DataW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SETPOINT:  cfg.setpoint = TempW'(val);
      REG_DEBOUNCE:  cfg.debounce = RunW'(val);
      REG_PERIOD:    cfg.period = PhaseW'(val);
      REG_AUTO_OFF:  cfg.auto_off = AgeW'(val);
      REG_HEAT_DEAD: cfg.heat_dead = SinceW'(val);
      REG_PUMP_DEAD: cfg.pump_dead = SinceW'(val);
      default: ;
    endcase
  endtask

  task automatic program_regs(int setpoint, int debounce, int period, int auto_off,
                              int heat_dead, int pump_dead);
    write_reg(REG_SETPOINT, setpoint);
    write_reg(REG_DEBOUNCE, debounce);
    write_reg(REG_PERIOD, period);
    write_reg(REG_AUTO_OFF, auto_off);
    write_reg(REG_HEAT_DEAD, heat_dead);
    write_reg(REG_PUMP_DEAD, pump_dead);
  endtask

  task automatic push_tick(logic button, int sample, logic open, cmd_e cmd);
    tick_t t;
    t.button = button;
    t.sample = TempW'(sample);
    t.open = open;
    t.cmd = cmd;
    ticks_to_send.push_back(t);
  endtask

  // Held button runs with glitches, samples mostly near the setpoint.
  task automatic queue_random(int n);
    int    run_len;
    int    sp;
    int    roll;
    logic  lvl;
    tick_t t;
    run_len = 0;
    lvl = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (run_len == 0) begin
        lvl = 1'($urandom_range(1));
        run_len = $urandom_range(24, 1);
      end
      run_len--;
      t.button = ($urandom_range(99) < 8) ? !lvl : lvl;
      roll = $urandom_range(99);
      t.cmd = (roll < 3) ? CMD_OFF : ((roll < 9) ? CMD_ON : CMD_NONE);
      if ($urandom_range(99) < 70) begin
        sp = int'(cfg.setpoint) + int'($urandom_range(80)) - 40;
        if (sp < 0) sp = 0;
        if (sp > 4095) sp = 4095;
        t.sample = TempW'(sp);
      end else begin
        t.sample = TempW'($urandom_range(4095));
      end
      t.open = ($urandom_range(99) < 4);
      ticks_to_send.push_back(t);
    end
  endtask

  task automatic drain();
    while (ticks_to_send.size() != 0 || s_axis_tvalid || due_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    reset_model();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    program_regs(400, 2, 1, int'(AgeMax), 0, 0);
    push_tick(1'b0, 0, 1'b0, CMD_NONE);
    push_tick(1'b0, 4095, 1'b0, CMD_NONE);
    push_tick(1'b0, 4095, 1'b1, CMD_NONE);
    push_tick(1'b0, 400, 1'b0, CMD_NONE);
    push_tick(1'b0, 400, 1'b0, CMD_NONE);
    push_tick(1'b0, 401, 1'b0, CMD_NONE);
    push_tick(1'b1, 400, 1'b0, CMD_NONE);
    push_tick(1'b1, 400, 1'b0, CMD_NONE);
    push_tick(1'b0, 400, 1'b0, CMD_NONE);
    push_tick(1'b1, 400, 1'b0, CMD_NONE);
    push_tick(1'b1, 400, 1'b0, CMD_OFF);
    push_tick(1'b0, 0, 1'b0, CMD_NONE);
    push_tick(1'b1, 4095, 1'b1, CMD_NONE);
    push_tick(1'b0, 400, 1'b0, CMD_ON);
    push_tick(1'b0, 400, 1'b0, CMD_ON);
    push_tick(1'b0, 400, 1'b0, CMD_NONE);
    push_tick(1'b0, 400, 1'b0, CMD_NONE);
    push_tick(1'b0, 400, 1'b0, CMD_OFF);
    drain();

    // auto power-off from ready
    program_regs(400, 1, 1, 3, 0, 0);
    push_tick(1'b0, 100, 1'b0, CMD_ON);
    for (int i = 0; i < 5; i++) push_tick(1'b0, 100, 1'b0, CMD_NONE);
    push_tick(1'b0, 100, 1'b0, CMD_ON);
    drain();

    program_regs(364, 5, 25, 360000, 100, 0);
    queue_random(148);
    drain();
    program_regs(0, 1, 1, 0, 0, 0);
    queue_random(148);
    drain();
    program_regs(4095, 15, 255, int'(AgeMax), 1000, 1000);
    queue_random(148);
    drain();
    for (int p = 0; p < 4; p++) begin
      program_regs($urandom_range(4095), $urandom_range(15, 1), $urandom_range(6, 1),
                   $urandom_range(300), $urandom_range(30), $urandom_range(30));
      queue_random(148);
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (due_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results expected, none arrived", $time, due_results.size());
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
